@@ src/pf6_pkg.sv @@
// Shared types, constants and coordinate helpers for the 6x6 Playfair encryptor.
// No dependencies; every other file in src takes what it needs from here.
package pf6_pkg;

    // Square geometry
    localparam int SIDE    = 6;
    localparam int CELLS   = SIDE * SIDE;
    localparam int SYM_W   = 6;
    localparam int COORD_W = 3;
    localparam int OP_W    = 2;

    typedef logic [SYM_W-1:0]   t_sym;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [OP_W-1:0]    t_op;

    // Item opcodes
    localparam t_op OP_KEY  = 2'd0;
    localparam t_op OP_TEXT = 2'd1;
    localparam t_op OP_END  = 2'd2;

    // Filler symbol: letter X
    localparam t_sym PAD_SYMBOL = t_sym'(23);

    // Write request into the square store: cell slot and the symbol it holds
    typedef struct packed {
        logic en;
        t_sym slot;
        t_sym sym;
    } t_sq_wr;

    // Row of a cell index, by comparison against each row start
    function automatic t_coord row_of(input t_sym p);
        t_coord r;
        r = '0;
        for (int i = 1; i < SIDE; i++) begin
            if (p >= t_sym'(i * SIDE)) begin
                r = t_coord'(i);
            end
        end
        return r;
    endfunction

    // Column of a cell index
    function automatic t_coord col_of(input t_sym p);
        t_sym base;
        base = t_sym'(row_of(p)) * t_sym'(SIDE);
        return t_coord'(p - base);
    endfunction

    // Step one row or column with wraparound
    function automatic t_coord next_coord(input t_coord x);
        return (x == t_coord'(SIDE - 1)) ? '0 : x + t_coord'(1);
    endfunction

    // Cell index from row and column
    function automatic t_sym cell_of(input t_coord r, input t_coord c);
        return t_sym'(r) * t_sym'(SIDE) + t_sym'(c);
    endfunction

endpackage

@@ src/pf6_in_if.sv @@
// Input channel of the Playfair encryptor: valid/ready with op and symbol.
// Depends on pf6_pkg.
interface pf6_in_if;
    logic            valid;
    logic            ready;
    pf6_pkg::t_op    op;
    pf6_pkg::t_sym   symbol;

    modport source (output valid, op, symbol, input ready);
    modport sink   (input valid, op, symbol, output ready);
endinterface

@@ src/pf6_out_if.sv @@
// Output channel of the Playfair encryptor: valid/ready with cipher symbol and last.
// Depends on pf6_pkg.
interface pf6_out_if;
    logic            valid;
    logic            ready;
    pf6_pkg::t_sym   cipher_symbol;
    logic            last;

    modport source (output valid, cipher_symbol, last, input ready);
    modport sink   (input valid, cipher_symbol, last, output ready);
endinterface

@@ src/pf6_square_store.sv @@
// Square storage: cell-to-symbol and symbol-to-cell memories, one write port
// shared by both, one registered read port each. Depends on pf6_pkg.
module pf6_square_store (
    input  logic             i_clk,
    input  pf6_pkg::t_sq_wr  i_wr,
    input  pf6_pkg::t_sym    i_pos_addr,
    output pf6_pkg::t_sym    o_pos_q,
    input  pf6_pkg::t_sym    i_cell_addr,
    output pf6_pkg::t_sym    o_cell_q
);

    pf6_pkg::t_sym r_cell_mem [pf6_pkg::CELLS];
    pf6_pkg::t_sym r_pos_mem  [pf6_pkg::CELLS];
    pf6_pkg::t_sym r_pos_q;
    pf6_pkg::t_sym r_cell_q;

    // Place a symbol: record it in its cell and the cell under the symbol
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_cell_mem[i_wr.slot] <= i_wr.sym;
            r_pos_mem[i_wr.sym]   <= i_wr.slot;
        end
    end

    // Registered reads
    always_ff @(posedge i_clk) begin
        r_pos_q  <= r_pos_mem[i_pos_addr];
        r_cell_q <= r_cell_mem[i_cell_addr];
    end

    assign o_pos_q  = r_pos_q;
    assign o_cell_q = r_cell_q;

endmodule

@@ src/playfair_6x6_encryptor.sv @@
// Playfair encryptor over a 6x6 square of A-Z and 0-9 (codes 0-35).
// Depends on pf6_pkg, pf6_in_if, pf6_out_if and pf6_square_store.
//
// Usage: items arrive on i_in (op, symbol) and cipher symbols leave on o_out
// (cipher_symbol, last). Op 0 places a key symbol, op 1 enciphers a plaintext
// symbol, op 2 ends the message. Items with a symbol above 35 (except end)
// and op 3 are dropped without results.
// The first plaintext item after the key sweeps the unused symbols into the
// square, one per cycle. A plaintext item that closes a pair yields two
// transfers, the second with last set; the sequencer reads the position
// memory and then the cell memory once per symbol through single read ports.
// An item that only opens a pair is held pending and yields no transfer.
// An end item flushes a lone symbol padded with X (two transfers), then
// clears the square for a new key.
// i_in.ready is high only while the sequencer is idle. A result sits in an
// output register, so the next item is taken while it waits; a stalled
// receiver holds the sequencer only when the next result is ready.
// Reset (synchronous, active low) empties the square and drops any result.
module playfair_6x6_encryptor (
    input  logic i_clk,
    input  logic i_rst_n,
    pf6_in_if.sink    i_in,
    pf6_out_if.source o_out
);

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_FILL   = 4'd2;
    localparam logic [3:0] S_TEXT   = 4'd3;
    localparam logic [3:0] S_POSA   = 4'd4;
    localparam logic [3:0] S_POSB   = 4'd5;
    localparam logic [3:0] S_RULE   = 4'd6;
    localparam logic [3:0] S_CELLA  = 4'd7;
    localparam logic [3:0] S_OUTA   = 4'd8;
    localparam logic [3:0] S_CELLB  = 4'd9;
    localparam logic [3:0] S_OUTB   = 4'd10;
    localparam logic [3:0] S_CLEAR  = 4'd11;

    localparam pf6_pkg::t_sym LAST_CELL = pf6_pkg::t_sym'(pf6_pkg::CELLS - 1);
    localparam pf6_pkg::t_sym NUM_CELLS = pf6_pkg::t_sym'(pf6_pkg::CELLS);

    // Control state
    logic [3:0]               r_state, n_state;
    logic [pf6_pkg::CELLS-1:0] r_used, n_used;
    pf6_pkg::t_sym            r_fill, n_fill;
    logic                     r_complete, n_complete;
    logic                     r_pend_v, n_pend_v;
    pf6_pkg::t_sym            r_scan, n_scan;
    logic                     r_out_valid, n_out_valid;

    // Payload state
    pf6_pkg::t_op             r_op, n_op;
    pf6_pkg::t_sym            r_sym, n_sym;
    pf6_pkg::t_sym            r_pend_sym, n_pend_sym;
    pf6_pkg::t_sym            r_a, n_a;
    pf6_pkg::t_sym            r_b, n_b;
    pf6_pkg::t_coord          r_ra, n_ra;
    pf6_pkg::t_coord          r_ca, n_ca;
    pf6_pkg::t_sym            r_oa, n_oa;
    pf6_pkg::t_sym            r_ob, n_ob;
    pf6_pkg::t_sym            r_out_sym, n_out_sym;
    logic                     r_out_last, n_out_last;

    // Datapath nets
    pf6_pkg::t_sq_wr          w_wr;
    logic                     w_place_en;
    pf6_pkg::t_sym            w_place_sym;
    pf6_pkg::t_sym            w_pos_addr;
    pf6_pkg::t_sym            w_pos_q;
    pf6_pkg::t_sym            w_cell_addr;
    pf6_pkg::t_sym            w_cell_q;
    pf6_pkg::t_coord          w_row;
    pf6_pkg::t_coord          w_col;
    logic                     w_in_xfer;
    logic                     w_out_free;

    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    // Square memories
    assign w_wr = '{en: w_place_en, slot: r_fill, sym: w_place_sym};
    assign w_pos_addr  = (r_state == S_POSA) ? r_a : r_b;
    assign w_cell_addr = (r_state == S_CELLA || r_state == S_OUTA) ? r_oa : r_ob;

    pf6_square_store u_store (
        .i_clk       (i_clk),
        .i_wr        (w_wr),
        .i_pos_addr  (w_pos_addr),
        .o_pos_q     (w_pos_q),
        .i_cell_addr (w_cell_addr),
        .o_cell_q    (w_cell_q)
    );

    // Shared coordinate unit on the position read data
    assign w_row = pf6_pkg::row_of(w_pos_q);
    assign w_col = pf6_pkg::col_of(w_pos_q);

    // Place a key symbol or sweep the next unused symbol into the square
    always_comb begin
        w_place_en  = 1'b0;
        w_place_sym = r_sym;
        if (r_state == S_DECODE) begin
            w_place_en = (r_op == pf6_pkg::OP_KEY) && (r_sym < NUM_CELLS) &&
                         !r_complete && !r_used[r_sym];
        end else if (r_state == S_FILL) begin
            w_place_sym = r_scan;
            w_place_en  = !r_used[r_scan];
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_fill      = r_fill;
        n_complete  = r_complete;
        n_pend_v    = r_pend_v;
        n_scan      = r_scan;
        n_out_valid = r_out_valid && !o_out.ready;
        n_op        = r_op;
        n_sym       = r_sym;
        n_pend_sym  = r_pend_sym;
        n_a         = r_a;
        n_b         = r_b;
        n_ra        = r_ra;
        n_ca        = r_ca;
        n_oa        = r_oa;
        n_ob        = r_ob;
        n_out_sym   = r_out_sym;
        n_out_last  = r_out_last;

        if (w_place_en) begin
            n_used[w_place_sym] = 1'b1;
            n_fill              = r_fill + pf6_pkg::t_sym'(1);
            if (r_fill == LAST_CELL) begin
                n_complete = 1'b1;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_op    = i_in.op;
                    n_sym   = i_in.symbol;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_scan = '0;
                if (r_op == pf6_pkg::OP_END) begin
                    n_a = r_pend_sym;
                    n_b = pf6_pkg::PAD_SYMBOL;
                    if (!r_pend_v) begin
                        n_state = S_CLEAR;
                    end else if (!r_complete) begin
                        n_state = S_FILL;
                    end else begin
                        n_state = S_POSA;
                    end
                end else if (r_op == pf6_pkg::OP_TEXT && r_sym < NUM_CELLS) begin
                    n_state = r_complete ? S_TEXT : S_FILL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FILL: begin
                n_scan = r_scan + pf6_pkg::t_sym'(1);
                if (r_scan == LAST_CELL) begin
                    n_complete = 1'b1;
                    n_state    = (r_op == pf6_pkg::OP_END) ? S_POSA : S_TEXT;
                end
            end
            S_TEXT: begin
                if (!r_pend_v) begin
                    n_pend_sym = r_sym;
                    n_pend_v   = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_a = r_pend_sym;
                    if (r_pend_sym == r_sym) begin
                        // Equal pair: pad with X, the symbol stays pending
                        n_b = pf6_pkg::PAD_SYMBOL;
                    end else begin
                        n_b      = r_sym;
                        n_pend_v = 1'b0;
                    end
                    n_state = S_POSA;
                end
            end
            S_POSA: begin
                n_state = S_POSB;
            end
            S_POSB: begin
                n_ra    = w_row;
                n_ca    = w_col;
                n_state = S_RULE;
            end
            S_RULE: begin
                // Same row, same column, or rectangle
                if (r_ra == w_row) begin
                    n_oa = pf6_pkg::cell_of(r_ra, pf6_pkg::next_coord(r_ca));
                    n_ob = pf6_pkg::cell_of(w_row, pf6_pkg::next_coord(w_col));
                end else if (r_ca == w_col) begin
                    n_oa = pf6_pkg::cell_of(pf6_pkg::next_coord(r_ra), r_ca);
                    n_ob = pf6_pkg::cell_of(pf6_pkg::next_coord(w_row), w_col);
                end else begin
                    n_oa = pf6_pkg::cell_of(r_ra, w_col);
                    n_ob = pf6_pkg::cell_of(w_row, r_ca);
                end
                n_state = S_CELLA;
            end
            S_CELLA: begin
                n_state = S_OUTA;
            end
            S_OUTA: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_sym   = w_cell_q;
                    n_out_last  = 1'b0;
                    n_state     = S_CELLB;
                end
            end
            S_CELLB: begin
                n_state = S_OUTB;
            end
            S_OUTB: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_sym   = w_cell_q;
                    n_out_last  = 1'b1;
                    n_state     = (r_op == pf6_pkg::OP_END) ? S_CLEAR : S_IDLE;
                end
            end
            S_CLEAR: begin
                n_used     = '0;
                n_fill     = '0;
                n_complete = 1'b0;
                n_pend_v   = 1'b0;
                n_pend_sym = '0;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_fill      <= '0;
            r_complete  <= 1'b0;
            r_pend_v    <= 1'b0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
            r_pend_sym  <= '0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_fill      <= n_fill;
            r_complete  <= n_complete;
            r_pend_v    <= n_pend_v;
            r_scan      <= n_scan;
            r_out_valid <= n_out_valid;
            r_pend_sym  <= n_pend_sym;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_sym      <= n_sym;
        r_a        <= n_a;
        r_b        <= n_b;
        r_ra       <= n_ra;
        r_ca       <= n_ca;
        r_oa       <= n_oa;
        r_ob       <= n_ob;
        r_out_sym  <= n_out_sym;
        r_out_last <= n_out_last;
    end

    // Ports
    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.cipher_symbol = r_out_sym;
    assign o_out.last          = r_out_last;

    // Placed count tracks the used flags
    a_fill_matches_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_used) == int'(r_fill))
        else $error("fill count out of step with used flags");

    // A complete square holds every cell
    a_complete_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_complete |-> (r_fill == NUM_CELLS))
        else $error("square marked complete while not full");

    // Lookups start only on a complete square
    a_lookup_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POSA) |-> r_complete)
        else $error("pair lookup on an incomplete square");

    // A new result is loaded only when the output register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out_sym)))
        else $error("pending result overwritten");

endmodule
